// ----- src/ecbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbs_pkg : shared types and helpers for the entity component bitmap store
// Row layout, transaction structs, operation codes and word-level functions.
// ----------------------------------------------------------------------------
package ecbs_pkg;

    localparam int CAPACITY  = 1024;
    localparam int NUM_TYPES = 8;
    localparam int WORD_BITS = 64;
    localparam int ROWS      = CAPACITY / WORD_BITS;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int POS_W     = $clog2(WORD_BITS);
    localparam int POP_W     = POS_W + 1;
    localparam int ID_W      = 10;
    localparam int CNT_W     = 11;
    localparam int TYPE_W    = 3;
    localparam int MASK_W    = 8;
    localparam int KIND_W    = 4;

    // Operation codes
    localparam logic [KIND_W-1:0] K_ALLOC      = 4'd0;
    localparam logic [KIND_W-1:0] K_REMOVE     = 4'd1;
    localparam logic [KIND_W-1:0] K_ADD        = 4'd2;
    localparam logic [KIND_W-1:0] K_DROP       = 4'd3;
    localparam logic [KIND_W-1:0] K_TEST       = 4'd4;
    localparam logic [KIND_W-1:0] K_RESET_TYPE = 4'd5;
    localparam logic [KIND_W-1:0] K_CLEAR      = 4'd6;
    localparam logic [KIND_W-1:0] K_NEXT       = 4'd7;
    localparam logic [KIND_W-1:0] K_COUNT      = 4'd8;
    localparam logic [KIND_W-1:0] K_SET_WHERE  = 4'd9;
    localparam logic [KIND_W-1:0] K_REM_WHERE  = 4'd10;
    localparam logic [KIND_W-1:0] K_ENS_WHERE  = 4'd11;
    localparam logic [KIND_W-1:0] K_HOLES      = 4'd12;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [NUM_TYPES-1:0][WORD_BITS-1:0] t_row;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   entity_id;
        logic [TYPE_W-1:0] component_type;
        logic [MASK_W-1:0] require_mask;
        logic [MASK_W-1:0] exclude_mask;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]  result_id;
        logic             found;
        logic [CNT_W-1:0] count;
    } t_out;

    // Control handed to the word unit for the row being processed
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TYPE_W-1:0] ctype;
        logic [MASK_W-1:0] req;
        logic [MASK_W-1:0] exc;
        logic [POS_W-1:0]  pos;
        logic              first;
    } t_wu_ctrl;

    // Word unit results
    typedef struct packed {
        t_row              row_out;
        logic              wr_en;
        logic              sel_nz;
        logic [POS_W-1:0]  lead;
        logic [POS_W-1:0]  trail;
        logic [POP_W-1:0]  pop;
        logic              live_bit;
        logic              type_bit;
    } t_wu_res;

    // Query key: live word, ANDed with required and inverted excluded types
    function automatic t_word f_key(t_row row, logic [MASK_W-1:0] req,
                                    logic [MASK_W-1:0] exc);
        t_word k;
        k = row[0];
        for (int t = 0; t < NUM_TYPES; t++) begin
            if (req[t]) k = k & row[t];
            if (exc[t]) k = k & ~row[t];
        end
        return k;
    endfunction

    // Position of the first set bit counted from the MSB
    function automatic logic [POS_W-1:0] f_lead(t_word v);
        logic [POS_W-1:0] r;
        r = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (v[WORD_BITS-1-k]) r = POS_W'(k);
        end
        return r;
    endfunction

    // Index of the lowest set bit counted from the LSB
    function automatic logic [POS_W-1:0] f_trail(t_word v);
        logic [POS_W-1:0] r;
        r = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (v[k]) r = POS_W'(k);
        end
        return r;
    endfunction

    function automatic logic [POP_W-1:0] f_pop(t_word v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            n = n + POP_W'(v[k]);
        end
        return n;
    endfunction

endpackage

// ----- src/ecbs_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbs_mem : bitmap row memory
// One row holds the words of every type for one block of 64 ids. Per-row
// valid bits make unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
module ecbs_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [ecbs_pkg::ROW_W-1:0]  i_wr_addr,
    input  ecbs_pkg::t_row              i_wr_data,
    input  logic                        i_rd_en,
    input  logic [ecbs_pkg::ROW_W-1:0]  i_rd_addr,
    output ecbs_pkg::t_row              o_rd_data
);

    ecbs_pkg::t_row                mem [ecbs_pkg::ROWS];
    logic [ecbs_pkg::ROWS-1:0]     r_vld;
    ecbs_pkg::t_row                r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Row valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read, invalid rows read as zero
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/ecbs_wu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbs_wu : shared word unit
// Works on one row: builds the query key, the updated row, and the search,
// count and position results for the operation in progress.
// ----------------------------------------------------------------------------
module ecbs_wu (
    input  ecbs_pkg::t_wu_ctrl i_ctrl,
    input  ecbs_pkg::t_row     i_row,
    output ecbs_pkg::t_wu_res  o_res
);

    ecbs_pkg::t_word bitm;
    ecbs_pkg::t_word mask;
    ecbs_pkg::t_word key;
    ecbs_pkg::t_word sel;
    ecbs_pkg::t_row  row_out;
    logic            wr_en;
    logic            live_bit;

    assign bitm     = {1'b1, {(ecbs_pkg::WORD_BITS-1){1'b0}}} >> i_ctrl.pos;
    assign mask     = {ecbs_pkg::WORD_BITS{1'b1}} >> i_ctrl.pos;
    assign key      = ecbs_pkg::f_key(i_row, i_ctrl.req, i_ctrl.exc);
    assign live_bit = |(i_row[0] & bitm);

    // Select the row update and the word to search or count
    always_comb begin
        row_out = i_row;
        wr_en   = 1'b0;
        sel     = '0;
        case (i_ctrl.kind)
            ecbs_pkg::K_ALLOC: begin
                if (i_ctrl.first) begin
                    row_out[0] = i_row[0] | bitm;
                    wr_en      = 1'b1;
                    sel        = ~(i_row[0] | bitm) & mask;
                end else begin
                    sel = ~i_row[0];
                end
            end
            ecbs_pkg::K_REMOVE: begin
                if (live_bit) begin
                    for (int t = 0; t < ecbs_pkg::NUM_TYPES; t++) begin
                        row_out[t] = i_row[t] & ~bitm;
                    end
                    wr_en = 1'b1;
                end
            end
            ecbs_pkg::K_ADD: begin
                if (live_bit) begin
                    row_out[i_ctrl.ctype] = i_row[i_ctrl.ctype] | bitm;
                    wr_en = 1'b1;
                end
            end
            ecbs_pkg::K_DROP: begin
                if (live_bit) begin
                    row_out[i_ctrl.ctype] = i_row[i_ctrl.ctype] & ~bitm;
                    wr_en = 1'b1;
                end
            end
            ecbs_pkg::K_RESET_TYPE: begin
                row_out[i_ctrl.ctype] = '0;
                wr_en = 1'b1;
            end
            ecbs_pkg::K_CLEAR: begin
                row_out = '0;
                wr_en   = 1'b1;
            end
            ecbs_pkg::K_NEXT: begin
                sel = i_ctrl.first ? (key & mask) : key;
            end
            ecbs_pkg::K_COUNT: begin
                sel = key;
            end
            ecbs_pkg::K_SET_WHERE: begin
                if (|key) begin
                    row_out[i_ctrl.ctype] = key;
                    wr_en = 1'b1;
                end
            end
            ecbs_pkg::K_REM_WHERE: begin
                if (|key) begin
                    row_out[i_ctrl.ctype] = i_row[i_ctrl.ctype] & ~key;
                    wr_en = 1'b1;
                end
            end
            ecbs_pkg::K_ENS_WHERE: begin
                if (|key) begin
                    row_out[i_ctrl.ctype] = i_row[i_ctrl.ctype] | key;
                    wr_en = 1'b1;
                end
            end
            ecbs_pkg::K_HOLES: begin
                sel = i_row[0];
            end
            default: begin
                sel = '0;
            end
        endcase
    end

    assign o_res.row_out  = row_out;
    assign o_res.wr_en    = wr_en;
    assign o_res.sel_nz   = |sel;
    assign o_res.lead     = ecbs_pkg::f_lead(sel);
    assign o_res.trail    = ecbs_pkg::f_trail(sel);
    assign o_res.pop      = ecbs_pkg::f_pop(sel);
    assign o_res.live_bit = live_bit;
    assign o_res.type_bit = |(i_row[i_ctrl.ctype] & bitm);

endmodule

// ----- src/entity_component_bitmap_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entity_component_bitmap_store : presence bitmap store for entities
// Sequencer over a 16-row bitmap memory and one shared word unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries one operation transaction
//   (t_in). Output channel o_out_valid / i_out_stall returns exactly one
//   result transaction (t_out) per operation, in order.
//   Single-row operations (remove, add, drop, test) read only the row of
//   their id. Scanning operations walk the rows one per cycle through the
//   memory read port, up to 16 rows. Allocate and next-match stop at the
//   first hit. Operations that do nothing (full store, type 0 writes, unused
//   codes) skip the scan and go straight to the result.
//   One operation is in progress at a time; o_in_stall is high meanwhile.
//   A finished result sits in the output register while the next operation
//   is accepted; if the receiver stalls, the following result waits inside.
//   Reset empties the store at once (per-row valid bits), no clearing pass.
// ----------------------------------------------------------------------------
module entity_component_bitmap_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ecbs_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ecbs_pkg::t_out  o_out_data
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    localparam logic [ecbs_pkg::CNT_W-1:0] CAP_C  = ecbs_pkg::CNT_W'(ecbs_pkg::CAPACITY);
    localparam logic [ecbs_pkg::ROW_W-1:0] LAST_R = ecbs_pkg::ROW_W'(ecbs_pkg::ROWS - 1);
    localparam logic [ecbs_pkg::CNT_W-1:0] CNT_W_WORD = ecbs_pkg::CNT_W'(ecbs_pkg::WORD_BITS);

    t_state                          r_state;
    logic [ecbs_pkg::KIND_W-1:0]     r_kind;
    logic [ecbs_pkg::ID_W-1:0]       r_id;
    logic [ecbs_pkg::TYPE_W-1:0]     r_type;
    logic [ecbs_pkg::MASK_W-1:0]     r_req;
    logic [ecbs_pkg::MASK_W-1:0]     r_exc;
    logic [ecbs_pkg::POS_W-1:0]      r_pos;
    logic                            r_first;
    logic                            r_issue;
    logic                            r_dv;
    logic [ecbs_pkg::ROW_W-1:0]      r_iss_blk;
    logic [ecbs_pkg::ROW_W-1:0]      r_dblk;
    logic [ecbs_pkg::ROW_W-1:0]      r_end;
    logic [ecbs_pkg::CNT_W-1:0]      r_lfid;
    logic [ecbs_pkg::CNT_W-1:0]      r_live;
    logic [ecbs_pkg::CNT_W-1:0]      r_cnt;
    logic [ecbs_pkg::CNT_W-1:0]      r_high;
    logic [ecbs_pkg::CNT_W-1:0]      r_pop;
    logic [ecbs_pkg::ID_W-1:0]       r_rid;
    logic                            r_found;
    logic                            r_out_valid;
    ecbs_pkg::t_out                  r_out;

    ecbs_pkg::t_row                  rd_row;
    ecbs_pkg::t_wu_ctrl              wu_ctrl;
    ecbs_pkg::t_wu_res               wu_res;
    logic                            in_acc;
    logic                            rd_en;
    logic                            wr_en;
    logic                            w_last;
    logic                            w_stop;
    logic                            w_hand;
    logic                            n_skip;
    logic [ecbs_pkg::ROW_W-1:0]      n_start;
    logic [ecbs_pkg::ROW_W-1:0]      n_end;
    logic [ecbs_pkg::CNT_W-1:0]      n_count;

    assign in_acc = i_in_valid && !o_in_stall;

    // Decode the incoming transaction
    always_comb begin
        n_skip  = 1'b0;
        n_start = '0;
        n_end   = LAST_R;
        case (i_in_data.kind)
            ecbs_pkg::K_ALLOC: begin
                n_skip  = (r_lfid == CAP_C);
                n_start = r_lfid[ecbs_pkg::ID_W-1:ecbs_pkg::POS_W];
            end
            ecbs_pkg::K_REMOVE, ecbs_pkg::K_TEST: begin
                n_start = i_in_data.entity_id[ecbs_pkg::ID_W-1:ecbs_pkg::POS_W];
                n_end   = n_start;
            end
            ecbs_pkg::K_ADD, ecbs_pkg::K_DROP: begin
                n_skip  = (i_in_data.component_type == '0);
                n_start = i_in_data.entity_id[ecbs_pkg::ID_W-1:ecbs_pkg::POS_W];
                n_end   = n_start;
            end
            ecbs_pkg::K_NEXT: begin
                n_start = i_in_data.entity_id[ecbs_pkg::ID_W-1:ecbs_pkg::POS_W];
            end
            ecbs_pkg::K_RESET_TYPE, ecbs_pkg::K_SET_WHERE,
            ecbs_pkg::K_REM_WHERE, ecbs_pkg::K_ENS_WHERE: begin
                n_skip = (i_in_data.component_type == '0);
            end
            ecbs_pkg::K_CLEAR, ecbs_pkg::K_COUNT, ecbs_pkg::K_HOLES: begin
                n_skip = 1'b0;
            end
            default: begin
                n_skip = 1'b1;
            end
        endcase
    end

    // Row memory and word unit
    assign rd_en  = (r_state == S_SCAN) && r_issue;
    assign wr_en  = (r_state == S_SCAN) && r_dv && wu_res.wr_en;
    assign w_last = r_dv && (r_dblk == r_end);
    assign w_stop = w_last || (r_dv && wu_res.sel_nz &&
                    (r_kind == ecbs_pkg::K_ALLOC || r_kind == ecbs_pkg::K_NEXT));
    assign w_hand = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    ecbs_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_dblk),
        .i_wr_data (wu_res.row_out),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_iss_blk),
        .o_rd_data (rd_row)
    );

    assign wu_ctrl.kind  = r_kind;
    assign wu_ctrl.ctype = r_type;
    assign wu_ctrl.req   = r_req;
    assign wu_ctrl.exc   = r_exc;
    assign wu_ctrl.pos   = r_pos;
    assign wu_ctrl.first = r_first;

    ecbs_wu u_wu (
        .i_ctrl (wu_ctrl),
        .i_row  (rd_row),
        .o_res  (wu_res)
    );

    // Count field of the result
    always_comb begin
        case (r_kind)
            ecbs_pkg::K_COUNT: n_count = r_cnt;
            ecbs_pkg::K_HOLES: n_count = r_high - r_pop;
            default:           n_count = r_live;
        endcase
    end

    // Sequencer, store bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_first     <= 1'b0;
            r_lfid      <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_hand) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind    <= i_in_data.kind;
                        r_id      <= i_in_data.entity_id;
                        r_type    <= i_in_data.component_type;
                        r_req     <= i_in_data.require_mask;
                        r_exc     <= i_in_data.exclude_mask;
                        r_pos     <= (i_in_data.kind == ecbs_pkg::K_ALLOC) ?
                                     r_lfid[ecbs_pkg::POS_W-1:0] :
                                     i_in_data.entity_id[ecbs_pkg::POS_W-1:0];
                        r_first   <= 1'b1;
                        r_found   <= 1'b0;
                        r_rid     <= '0;
                        r_cnt     <= '0;
                        r_high    <= '0;
                        r_pop     <= '0;
                        r_dv      <= 1'b0;
                        r_iss_blk <= n_start;
                        r_end     <= n_end;
                        r_issue   <= !n_skip;
                        r_state   <= n_skip ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Advance the read address, drop the row in flight on a stop
                    if (r_issue) begin
                        r_iss_blk <= r_iss_blk + 1'b1;
                    end
                    r_issue <= r_issue && (r_iss_blk != r_end) && !w_stop;
                    r_dv    <= r_issue && !w_stop;
                    r_dblk  <= r_iss_blk;
                    // Consume the row read last cycle
                    if (r_dv) begin
                        r_first <= 1'b0;
                        case (r_kind)
                            ecbs_pkg::K_ALLOC: begin
                                if (r_first) begin
                                    r_rid   <= r_lfid[ecbs_pkg::ID_W-1:0];
                                    r_found <= 1'b1;
                                    r_live  <= r_live + 1'b1;
                                end
                                if (wu_res.sel_nz) begin
                                    r_lfid <= {1'b0, r_dblk, wu_res.lead};
                                end else if (w_last) begin
                                    r_lfid <= CAP_C;
                                end
                            end
                            ecbs_pkg::K_REMOVE: begin
                                if (wu_res.live_bit) begin
                                    r_found <= 1'b1;
                                    r_live  <= r_live - 1'b1;
                                    if (r_lfid > {1'b0, r_id}) begin
                                        r_lfid <= {1'b0, r_id};
                                    end
                                end
                            end
                            ecbs_pkg::K_ADD: begin
                                r_found <= wu_res.live_bit;
                            end
                            ecbs_pkg::K_TEST: begin
                                r_found <= wu_res.type_bit;
                            end
                            ecbs_pkg::K_CLEAR: begin
                                if (w_last) begin
                                    r_live <= '0;
                                    r_lfid <= '0;
                                end
                            end
                            ecbs_pkg::K_NEXT: begin
                                if (wu_res.sel_nz) begin
                                    r_rid   <= {r_dblk, wu_res.lead};
                                    r_found <= 1'b1;
                                end
                            end
                            ecbs_pkg::K_COUNT: begin
                                r_cnt <= r_cnt + ecbs_pkg::CNT_W'(wu_res.pop);
                            end
                            ecbs_pkg::K_HOLES: begin
                                if (wu_res.sel_nz) begin
                                    r_high <= {1'b0, r_dblk, {ecbs_pkg::POS_W{1'b0}}}
                                              + CNT_W_WORD
                                              - ecbs_pkg::CNT_W'(wu_res.trail);
                                end
                                r_pop <= r_pop + ecbs_pkg::CNT_W'(wu_res.pop);
                            end
                            default: begin
                                r_found <= r_found;
                            end
                        endcase
                        if (w_stop) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    // Hand the result over once the output register is free
                    if (w_hand) begin
                        r_out.result_id <= r_rid;
                        r_out.found     <= r_found;
                        r_out.count     <= n_count;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Live count never exceeds capacity
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CAP_C)
        else $error("live count beyond capacity");

    // Lowest free id is an id or the full marker
    a_lfid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfid <= CAP_C)
        else $error("lowest free id beyond capacity");

    // An accepted transaction makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("block not busy after accepting a transaction");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the entity component bitmap store
// Drives operation transactions through the valid/stall input channel, keeps
// a bit-accurate shadow of the presence bitmaps, and compares every result
// transaction field by field, in order, under varied idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WPT       = ecbs_pkg::CAPACITY / ecbs_pkg::WORD_BITS;
    localparam int WDOG_MAX  = 20000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    ecbs_pkg::t_in    i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    ecbs_pkg::t_out   o_out_data;

    entity_component_bitmap_store u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Shadow of the store
    logic [ecbs_pkg::WORD_BITS-1:0] shadow_words [ecbs_pkg::NUM_TYPES][WPT];
    int unsigned          shadow_free;
    int unsigned          shadow_live;

    ecbs_pkg::t_out result_queue [$];
    int     mismatch_count;
    int     ops_sent;
    int     results_seen;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off_req;
    int     hold_off_seen;
    int     hold_off_cycles;
    int     quiet_cycles;
    int     kind_hits [16];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [ecbs_pkg::WORD_BITS-1:0] id_mask(int unsigned id);
        return 64'h1 << (63 - (id % 64));
    endfunction

    function automatic logic bit_of(int unsigned ty, int unsigned id);
        return (shadow_words[ty][id / 64] & id_mask(id)) != 0;
    endfunction

    function automatic logic [ecbs_pkg::WORD_BITS-1:0] match_key(int b, logic [7:0] req,
                                                                 logic [7:0] exc);
        logic [ecbs_pkg::WORD_BITS-1:0] k;
        k = shadow_words[0][b];
        for (int t = 0; t < ecbs_pkg::NUM_TYPES; t++) begin
            if (req[t]) k = k & shadow_words[t][b];
            if (exc[t]) k = k & ~shadow_words[t][b];
        end
        return k;
    endfunction

    // Apply one operation to the shadow and return the result it predicts
    function automatic ecbs_pkg::t_out predict_store_op(ecbs_pkg::t_in op);
        ecbs_pkg::t_out r;
        logic [ecbs_pkg::WORD_BITS-1:0] k;
        int unsigned id, ty, high, pop, cnt, low;
        logic ty_w;
        r = '0;
        id = op.entity_id;
        ty = op.component_type;
        ty_w = (ty != 0);
        case (op.kind)
            ecbs_pkg::K_ALLOC: begin
                if (shadow_free < ecbs_pkg::CAPACITY) begin
                    r.result_id = shadow_free[ecbs_pkg::ID_W-1:0];
                    shadow_words[0][shadow_free / 64] |= id_mask(shadow_free);
                    shadow_live++;
                    r.found = 1'b1;
                    while (shadow_free < ecbs_pkg::CAPACITY && bit_of(0, shadow_free))
                        shadow_free++;
                end
            end
            ecbs_pkg::K_REMOVE: begin
                if (bit_of(0, id)) begin
                    for (int t = 0; t < ecbs_pkg::NUM_TYPES; t++)
                        shadow_words[t][id / 64] &= ~id_mask(id);
                    shadow_live--;
                    if (shadow_free > id) shadow_free = id;
                    r.found = 1'b1;
                end
            end
            ecbs_pkg::K_ADD, ecbs_pkg::K_DROP: begin
                if (ty_w && bit_of(0, id)) begin
                    if (op.kind == ecbs_pkg::K_ADD)
                        shadow_words[ty][id / 64] |= id_mask(id);
                    else
                        shadow_words[ty][id / 64] &= ~id_mask(id);
                    r.found = bit_of(ty, id);
                end
            end
            ecbs_pkg::K_TEST: r.found = bit_of(ty, id);
            ecbs_pkg::K_RESET_TYPE: begin
                if (ty_w)
                    for (int b = 0; b < WPT; b++) shadow_words[ty][b] = '0;
            end
            ecbs_pkg::K_CLEAR: begin
                for (int t = 0; t < ecbs_pkg::NUM_TYPES; t++)
                    for (int b = 0; b < WPT; b++) shadow_words[t][b] = '0;
                shadow_live = 0;
                shadow_free = 0;
            end
            ecbs_pkg::K_NEXT: begin
                for (int b = id / 64; b < WPT; b++) begin
                    k = match_key(b, op.require_mask, op.exclude_mask);
                    if (b == id / 64) k &= {ecbs_pkg::WORD_BITS{1'b1}} >> (id % 64);
                    if (k != 0) begin
                        for (int p = 63; p >= 0; p--)
                            if (k[p]) begin
                                r.result_id = ecbs_pkg::ID_W'(b * 64 + 63 - p);
                                break;
                            end
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            ecbs_pkg::K_SET_WHERE, ecbs_pkg::K_REM_WHERE, ecbs_pkg::K_ENS_WHERE: begin
                if (ty_w)
                    for (int b = 0; b < WPT; b++) begin
                        k = match_key(b, op.require_mask, op.exclude_mask);
                        if (k != 0) begin
                            if (op.kind == ecbs_pkg::K_SET_WHERE)
                                shadow_words[ty][b] = k;
                            else if (op.kind == ecbs_pkg::K_REM_WHERE)
                                shadow_words[ty][b] &= ~k;
                            else
                                shadow_words[ty][b] |= k;
                        end
                    end
            end
            default: ;
        endcase
        cnt = shadow_live;
        if (op.kind == ecbs_pkg::K_COUNT) begin
            cnt = 0;
            for (int b = 0; b < WPT; b++)
                cnt += $countones(match_key(b, op.require_mask, op.exclude_mask));
        end else if (op.kind == ecbs_pkg::K_HOLES) begin
            high = 0;
            pop = 0;
            for (int b = 0; b < WPT; b++) begin
                k = shadow_words[0][b];
                if (k != 0) begin
                    low = 0;
                    while (!k[low]) low++;
                    high = b * 64 + 64 - low;
                end
                pop += $countones(k);
            end
            cnt = high - pop;
        end
        r.count = ecbs_pkg::CNT_W'(cnt);
        return r;
    endfunction

    // Offer one operation and hold it until the block takes it
    task automatic send_op(ecbs_pkg::t_in op);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        result_queue.push_back(predict_store_op(op));
        kind_hits[op.kind]++;
        ops_sent++;
    endtask

    function automatic ecbs_pkg::t_in make_op(logic [3:0] kind, int id = 0, int ty = 0,
                                              logic [7:0] req = 0, logic [7:0] exc = 0);
        ecbs_pkg::t_in op;
        op.kind           = kind;
        op.entity_id      = ecbs_pkg::ID_W'(id);
        op.component_type = ecbs_pkg::TYPE_W'(ty);
        op.require_mask   = req;
        op.exclude_mask   = exc;
        return op;
    endfunction

    // Stop offering and wait until every expected result has come
    task automatic wait_drained();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (result_queue.size() != 0 && guard < WDOG_MAX) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Receiver stall: random idling or a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall     <= 1'b0;
            hold_off_seen   <= 0;
            hold_off_cycles <= 0;
        end else if (hold_off_req != hold_off_seen) begin
            hold_off_seen   <= hold_off_req;
            hold_off_cycles <= 300;
            i_out_stall     <= 1'b1;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_stall     <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        ecbs_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (result_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transaction: %p", o_out_data);
            end else begin
                want = result_queue.pop_front();
                if (want.result_id !== o_out_data.result_id
                        || want.found !== o_out_data.found
                        || want.count !== o_out_data.count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Mismatch: expected id %0d found %0d count %0d, ",
                                  "got id %0d found %0d count %0d"},
                                 want.result_id, want.found, want.count,
                                 o_out_data.result_id, o_out_data.found,
                                 o_out_data.count);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("Watchdog: no progress, %0d results outstanding", result_queue.size());
            $display("** entity_component_bitmap_store: FAILED **");
            $finish;
        end
    end

    task automatic test_directed();
        send_op(make_op(ecbs_pkg::K_HOLES));
        send_op(make_op(ecbs_pkg::K_ALLOC));
        send_op(make_op(ecbs_pkg::K_ALLOC));
        send_op(make_op(ecbs_pkg::K_ALLOC));
        send_op(make_op(ecbs_pkg::K_ADD, 1, 7));
        send_op(make_op(ecbs_pkg::K_ADD, 2, 0));
        send_op(make_op(ecbs_pkg::K_ADD, 500, 3));
        send_op(make_op(ecbs_pkg::K_TEST, 1, 7));
        send_op(make_op(ecbs_pkg::K_TEST, 1023, 7));
        send_op(make_op(ecbs_pkg::K_REMOVE, 1));
        send_op(make_op(ecbs_pkg::K_REMOVE, 1));
        send_op(make_op(ecbs_pkg::K_HOLES));
        send_op(make_op(ecbs_pkg::K_DROP, 0, 7));
        send_op(make_op(ecbs_pkg::K_ENS_WHERE, 0, 5, 8'h01, 8'h00));
        send_op(make_op(ecbs_pkg::K_SET_WHERE, 0, 6, 8'h21, 8'h00));
        send_op(make_op(ecbs_pkg::K_REM_WHERE, 0, 5, 8'hFF, 8'h00));
        send_op(make_op(ecbs_pkg::K_SET_WHERE, 0, 0, 8'h00, 8'h00));
        send_op(make_op(ecbs_pkg::K_NEXT, 0, 0, 8'h00, 8'h01));
        send_op(make_op(ecbs_pkg::K_NEXT, 1, 0, 8'h20, 8'h80));
        send_op(make_op(ecbs_pkg::K_NEXT, 1023, 0, 8'h00, 8'h00));
        send_op(make_op(ecbs_pkg::K_COUNT, 0, 0, 8'hFF, 8'hFE));
        send_op(make_op(ecbs_pkg::K_RESET_TYPE, 0, 6));
        send_op(make_op(4'd15, 1023, 7, 8'hFF, 8'hFF));
        send_op(make_op(ecbs_pkg::K_CLEAR));
        send_op(make_op(ecbs_pkg::K_ALLOC));
    endtask

    // Fill a large block of ids so that long scans and later rows are reached
    task automatic test_full_store();
        for (int i = 0; i < 300; i++) send_op(make_op(ecbs_pkg::K_ALLOC));
        send_op(make_op(ecbs_pkg::K_ADD, 1023, 4));
        send_op(make_op(ecbs_pkg::K_NEXT, 1000, 0, 8'h10, 8'h00));
        send_op(make_op(ecbs_pkg::K_REMOVE, 1023));
        send_op(make_op(ecbs_pkg::K_REMOVE, 64));
        send_op(make_op(ecbs_pkg::K_HOLES));
        send_op(make_op(ecbs_pkg::K_ALLOC));
        send_op(make_op(ecbs_pkg::K_ALLOC));
        send_op(make_op(ecbs_pkg::K_CLEAR));
    endtask

    // Random operations biased toward ids in a small region
    task automatic test_random(int n);
        ecbs_pkg::t_in op;
        int unsigned r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            op.kind           = (r < 25) ? ecbs_pkg::K_ALLOC
                                         : ecbs_pkg::KIND_W'($urandom_range(15));
            op.entity_id      = ($urandom_range(9) < 8) ? ecbs_pkg::ID_W'($urandom_range(191))
                                                        : ecbs_pkg::ID_W'($urandom);
            op.component_type = ecbs_pkg::TYPE_W'($urandom);
            op.require_mask   = 8'($urandom) & ($urandom_range(1) ? 8'hFF : 8'h0F);
            op.exclude_mask   = 8'($urandom) & ($urandom_range(1) ? 8'hFE : 8'hFF);
            if (op.kind == ecbs_pkg::K_CLEAR && $urandom_range(3) != 0)
                op.kind = ecbs_pkg::K_ADD;
            send_op(op);
        end
    endtask

    // Long receiver hold-off while operations keep arriving
    task automatic test_backpressure();
        hold_off_req++;
        test_random(20);
        wait_drained();
        test_random(10);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        ops_sent        = 0;
        hold_off_req    = 0;
        send_idle_pct   = 20;
        recv_idle_pct   = 87;
        foreach (kind_hits[i]) kind_hits[i] = 0;
        for (int t = 0; t < ecbs_pkg::NUM_TYPES; t++)
            for (int b = 0; b < WPT; b++) shadow_words[t][b] = '0;
        shadow_free = 0;
        shadow_live = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(150);
        send_idle_pct = 87;
        recv_idle_pct = 20;
        test_random(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_store();
        test_random(150);
        test_backpressure();

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Ran %0d operations, %0d results; allocs %0d, queries %0d, where-ops %0d",
                 ops_sent, results_seen, kind_hits[ecbs_pkg::K_ALLOC],
                 kind_hits[ecbs_pkg::K_NEXT] + kind_hits[ecbs_pkg::K_COUNT],
                 kind_hits[ecbs_pkg::K_SET_WHERE] + kind_hits[ecbs_pkg::K_REM_WHERE]
                 + kind_hits[ecbs_pkg::K_ENS_WHERE]);
        if (mismatch_count == 0 && result_queue.size() == 0) begin
            $display("** entity_component_bitmap_store: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     result_queue.size());
            $display("** entity_component_bitmap_store: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ecbs_pkg.sv
src/ecbs_mem.sv
src/ecbs_wu.sv
src/entity_component_bitmap_store.sv
test/tb_top.sv
